// ===== sv/dirty_rect_accumulator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Dirty rectangle accumulator assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef DIRTY_RECT_ACCUMULATOR_UNIT_MACROS_SVH
`define DIRTY_RECT_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define DRAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/drau_pkg.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle accumulator package
// Shared types, modes and defaults.
// ----------------------------------------------------------------------------
package drau_pkg;

  localparam int unsigned MAX_RECTS_DEF = 8;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_MERGE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] w;
    logic        [15:0] h;
  } rect_t;

endpackage

// ===== sv/drau_in_if.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle accumulator input channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface drau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [15:0]        rect_width;
  logic [15:0]        rect_height;
  logic               source_full;
  logic               source_last;
  logic [31:0]        source_frame;
  logic [63:0]        source_time;
  logic [2:0]         read_slot;

  modport source (
    output valid, mode, rect_x, rect_y, rect_width, rect_height,
           source_full, source_last, source_frame, source_time, read_slot,
    input  ready
  );

  modport sink (
    input  valid, mode, rect_x, rect_y, rect_width, rect_height,
           source_full, source_last, source_frame, source_time, read_slot,
    output ready
  );
endinterface

// ===== sv/drau_out_if.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle accumulator output channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface drau_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [15:0]        out_width;
  logic [15:0]        out_height;
  logic [3:0]         held_count;
  logic               is_full_screen;
  logic [31:0]        held_frame;
  logic [63:0]        held_time;
  logic               collapsed;

  modport source (
    output valid, out_x, out_y, out_width, out_height, held_count,
           is_full_screen, held_frame, held_time, collapsed,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_width, out_height, held_count,
           is_full_screen, held_frame, held_time, collapsed,
    output ready
  );
endinterface

// ===== sv/dirty_rect_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle accumulator
// Holds one pending present request: up to MAX_RECTS dirty rectangles, a
// full-screen mark, a frame id and a submit time. in_i takes one request beat
// (start target, merge rectangle, read slot); out_o returns one result beat
// per request. Start, read and plain append pass from accept through the
// EXEC, RD and OUT states to out_o.valid; a merge into a full store walks
// every stored rectangle through one bounding-box compare unit, one per cycle
// off the store's read port, and the SCAN, LAST and FIN states fold them and
// write the box to slot 0 before RD and OUT. in_i.ready is high only while the
// sequencer is idle, so one request is in flight at a time; it rises together
// with out_o.valid. A result waiting on out_o does not block the next accept;
// if out_o is still stalled when that request finishes, the sequencer holds
// until the result register frees. Reset empties the store count, clears the
// full-screen mark, frame id and time, and drops out_o.valid; the slot
// contents are not cleared.
// ----------------------------------------------------------------------------
`include "dirty_rect_accumulator_unit_macros.svh"

module dirty_rect_accumulator_unit #(
  parameter int unsigned MAX_RECTS = drau_pkg::MAX_RECTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  drau_in_if.sink    in_i,
  drau_out_if.source out_o
);

  localparam int unsigned IdxW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CntW    = $clog2(MAX_RECTS + 1);
  localparam int unsigned SlotExW = (IdxW > 3) ? IdxW : 3;
  localparam int unsigned CntExW  = (CntW > 4) ? CntW : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full_q, full_d;
  logic [31:0]     frame_q, frame_d;
  logic [63:0]     time_q, time_d;
  logic            coll_q, coll_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            acc_en_q;

  // latched request
  logic [1:0]      mode_q;
  drau_pkg::rect_t item_q;
  logic            src_full_q;
  logic            src_last_q;
  logic [31:0]     src_frame_q;
  logic [63:0]     src_time_q;
  logic [2:0]      slot_q;

  // bounding box
  logic signed [15:0] min_x_q, min_y_q, min_x_d, min_y_d;
  logic signed [17:0] max_x_q, max_y_q, max_x_d, max_y_d;

  // store ports
  logic            we;
  logic [IdxW-1:0] waddr;
  drau_pkg::rect_t wdata;
  logic            re;
  logic [IdxW-1:0] raddr;
  drau_pkg::rect_t rdata;

  // result register
  logic               out_vld_q;
  drau_pkg::rect_t    out_rect_q;
  logic [3:0]         out_cnt_q;
  logic               out_full_q;
  logic [31:0]        out_frame_q;
  logic [63:0]        out_time_q;
  logic               out_coll_q;

  logic               in_fire;
  logic               out_free;
  logic               slot_ok;
  logic [SlotExW-1:0] slot_ex;
  logic [IdxW-1:0]    rd_sel;
  logic [CntExW-1:0]  cnt_ex;
  logic signed [17:0] cand_rx, cand_ry, item_rx, item_ry;
  logic signed [17:0] span_x, span_y;
  logic [15:0]        sat_w, sat_h;
  drau_pkg::rect_t    bbox;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign slot_ex = SlotExW'(slot_q);
  assign slot_ok = (32'(slot_q) < 32'(MAX_RECTS));
  assign rd_sel  = (mode_q == drau_pkg::MODE_READ && slot_ok) ? slot_ex[IdxW-1:0] : '0;
  assign cnt_ex  = CntExW'(count_q);

  // right/bottom edges
  assign cand_rx = 18'(rdata.x) + $signed({2'b00, rdata.w});
  assign cand_ry = 18'(rdata.y) + $signed({2'b00, rdata.h});
  assign item_rx = 18'(item_q.x) + $signed({2'b00, item_q.w});
  assign item_ry = 18'(item_q.y) + $signed({2'b00, item_q.h});

  assign span_x = max_x_q - 18'(min_x_q);
  assign span_y = max_y_q - 18'(min_y_q);
  assign sat_w  = (span_x[17:16] != 2'b00) ? 16'hFFFF : span_x[15:0];
  assign sat_h  = (span_y[17:16] != 2'b00) ? 16'hFFFF : span_y[15:0];

  always_comb begin
    bbox.x = min_x_q;
    bbox.y = min_y_q;
    bbox.w = sat_w;
    bbox.h = sat_h;
  end

  // shared compare unit: one stored rectangle per cycle
  always_comb begin
    min_x_d = min_x_q;
    min_y_d = min_y_q;
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    if (state_q == S_EXEC) begin
      min_x_d = item_q.x;
      min_y_d = item_q.y;
      max_x_d = item_rx;
      max_y_d = item_ry;
    end else if (acc_en_q) begin
      if (rdata.x < min_x_q) min_x_d = rdata.x;
      if (rdata.y < min_y_q) min_y_d = rdata.y;
      if (cand_rx > max_x_q) max_x_d = cand_rx;
      if (cand_ry > max_y_q) max_y_d = cand_ry;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    full_d  = full_q;
    frame_d = frame_q;
    time_d  = time_q;
    coll_d  = coll_q;
    idx_d   = idx_q;
    we      = 1'b0;
    waddr   = count_q[IdxW-1:0];
    wdata   = item_q;
    re      = 1'b0;
    raddr   = rd_sel;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          coll_d  = 1'b0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RD;
        if (mode_q == drau_pkg::MODE_START) begin
          count_d = '0;
          full_d  = 1'b0;
          frame_d = src_frame_q;
          time_d  = src_time_q;
        end else if (mode_q == drau_pkg::MODE_MERGE) begin
          if (src_full_q) begin
            count_d = '0;
            full_d  = 1'b1;
          end else if (!full_q) begin
            if (count_q < CntW'(MAX_RECTS)) begin
              we      = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
            if (src_last_q) begin
              frame_d = src_frame_q;
              if (src_time_q > time_q) time_d = src_time_q;
            end
          end
        end
      end
      S_SCAN: begin
        re    = 1'b1;
        raddr = idx_q;
        if (idx_q == IdxW'(MAX_RECTS - 1)) begin
          state_d = S_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = bbox;
        count_d = CntW'(1);
        coll_d  = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  drau_rect_ram #(
    .Depth (MAX_RECTS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      full_q   <= 1'b0;
      frame_q  <= '0;
      time_q   <= '0;
      coll_q   <= 1'b0;
      idx_q    <= '0;
      acc_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      full_q   <= full_d;
      frame_q  <= frame_d;
      time_q   <= time_d;
      coll_q   <= coll_d;
      idx_q    <= idx_d;
      acc_en_q <= (state_q == S_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q      <= in_i.mode;
      item_q.x    <= in_i.rect_x;
      item_q.y    <= in_i.rect_y;
      item_q.w    <= in_i.rect_width;
      item_q.h    <= in_i.rect_height;
      src_full_q  <= in_i.source_full;
      src_last_q  <= in_i.source_last;
      src_frame_q <= in_i.source_frame;
      src_time_q  <= in_i.source_time;
      slot_q      <= in_i.read_slot;
    end
    min_x_q <= min_x_d;
    min_y_q <= min_y_d;
    max_x_q <= max_x_d;
    max_y_q <= max_y_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      if (mode_q == drau_pkg::MODE_READ && !slot_ok) begin
        out_rect_q <= '0;
      end else begin
        out_rect_q <= rdata;
      end
      out_cnt_q   <= cnt_ex[3:0];
      out_full_q  <= full_q;
      out_frame_q <= frame_q;
      out_time_q  <= time_q;
      out_coll_q  <= coll_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_x          = out_rect_q.x;
  assign out_o.out_y          = out_rect_q.y;
  assign out_o.out_width      = out_rect_q.w;
  assign out_o.out_height     = out_rect_q.h;
  assign out_o.held_count     = out_cnt_q;
  assign out_o.is_full_screen = out_full_q;
  assign out_o.held_frame     = out_frame_q;
  assign out_o.held_time      = out_time_q;
  assign out_o.collapsed      = out_coll_q;

  `DRAU_ASSERT_IMP(a_full_empty, full_q, count_q == '0, "full-screen target holds rectangles")
  `DRAU_ASSERT_IMP(a_scan_full, state_q == S_SCAN, count_q == CntW'(MAX_RECTS), "scan on partial store")
  `DRAU_ASSERT_NXT(a_fin_count, state_q == S_FIN, count_q == CntW'(1) && coll_q, "collapse did not finish")
  `DRAU_ASSERT_IMP(a_out_src, $rose(out_vld_q), $past(state_q) == S_OUT, "result without sequencer")

endmodule

// ===== sv/drau_rect_ram.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drau_rect_ram #(
  parameter int unsigned Depth = drau_pkg::MAX_RECTS_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  drau_pkg::rect_t      wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output drau_pkg::rect_t      rdata_o
);

  drau_pkg::rect_t mem [Depth];
  drau_pkg::rect_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
